/* sv/ps2mpd_pkg.sv */
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2mpd_pkg;

	localparam int BUTTON_COUNT = 3;
	// buttons examined per packet, capped by the 3-bit button state
	localparam int BtnN = (BUTTON_COUNT > 3) ? 3 : BUTTON_COUNT;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW = 1;
	localparam int QueueCntW = 2;

	typedef enum logic [1:0] {
		EV_MOVE     = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_RELEASED = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		POS_BTN = 2'd0,
		POS_X   = 2'd1,
		POS_Y   = 2'd2
	} byte_pos_t;

	// one completed packet, reduced to the events it still has to produce
	typedef struct packed {
		logic               has_move;
		logic [7:0]         dx;
		logic [7:0]         dy;
		logic [BtnN-1:0]    changed;
		logic [BtnN-1:0]    prev;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} queue_ctl_t;

endpackage

/* sv/ps2mpd_front.sv */
// Front end: assembles packets from the byte stream and classifies them into jobs.
module ps2mpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                aux_flag,
	input  logic [7:0]          data_byte,
	input  logic                queue_full,
	output logic                job_push,
	output ps2mpd_pkg::job_t    job
);

	ps2mpd_pkg::byte_pos_t           pos_q;
	logic [7:0]                      byte0_q;
	logic [7:0]                      byte1_q;
	logic [ps2mpd_pkg::BtnN-1:0]     prev_q;
	logic [ps2mpd_pkg::BtnN-1:0]     cur_bits;
	logic                            take;
	logic                            third;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready && aux_flag;
	assign third    = (pos_q != ps2mpd_pkg::POS_BTN) && (pos_q != ps2mpd_pkg::POS_X);
	assign cur_bits = byte0_q[ps2mpd_pkg::BtnN-1:0];

	always_comb begin
		job.has_move = (byte1_q != 8'd0) || (data_byte != 8'd0);
		job.dx       = byte1_q;
		job.dy       = 8'(8'd0 - data_byte);
		job.changed  = cur_bits ^ prev_q;
		job.prev     = prev_q;
	end

	// packets with no movement and no button change produce nothing
	assign job_push = take && third && (job.has_move || (job.changed != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ps2mpd_pkg::POS_BTN;
			prev_q <= '0;
		end else if (take) begin
			case (pos_q)
				ps2mpd_pkg::POS_BTN: pos_q <= ps2mpd_pkg::POS_X;
				ps2mpd_pkg::POS_X:   pos_q <= ps2mpd_pkg::POS_Y;
				default: begin
					pos_q  <= ps2mpd_pkg::POS_BTN;
					prev_q <= cur_bits;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && pos_q == ps2mpd_pkg::POS_BTN) begin
			byte0_q <= data_byte;
		end
		if (take && pos_q == ps2mpd_pkg::POS_X) begin
			byte1_q <= data_byte;
		end
	end

endmodule

/* sv/ps2mpd_queue.sv */
// Short job queue between the front end and the event generator.
module ps2mpd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ps2mpd_pkg::job_t        wr_job,
	input  logic                    pop,
	output ps2mpd_pkg::job_t        rd_job,
	output ps2mpd_pkg::queue_ctl_t  ctl
);

	ps2mpd_pkg::job_t                       mem_q [ps2mpd_pkg::QueueDepth];
	logic [ps2mpd_pkg::QueuePtrW-1:0]       wr_ptr_q;
	logic [ps2mpd_pkg::QueuePtrW-1:0]       rd_ptr_q;
	logic [ps2mpd_pkg::QueueCntW-1:0]       count_q;
	logic                                   do_push;
	logic                                   do_pop;

	assign ctl.full  = (count_q == ps2mpd_pkg::QueueCntW'(ps2mpd_pkg::QueueDepth));
	assign ctl.empty = (count_q == '0);
	assign do_push   = push && !ctl.full;
	assign do_pop    = pop && !ctl.empty;
	assign ctl.push  = do_push;
	assign ctl.pop   = do_pop;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

/* sv/ps2mpd_back.sv */
// Back end: expands each job into move and button events, one per cycle unless stalled.
module ps2mpd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_avail,
	input  ps2mpd_pkg::job_t        job,
	output logic                    job_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ps2mpd_pkg::event_kind_t event_kind,
	output logic [7:0]              move_x,
	output logic [7:0]              move_y,
	output logic [1:0]              button_number,
	output logic                    last
);

	logic                           cur_valid_q;
	logic                           move_pend_q;
	logic [ps2mpd_pkg::BtnN-1:0]    btn_pend_q;
	logic [ps2mpd_pkg::BtnN-1:0]    prev_q;
	logic [7:0]                     dx_q;
	logic [7:0]                     dy_q;

	logic                           slot_free;
	logic                           adv;
	logic [ps2mpd_pkg::BtnN-1:0]    btn_sel;
	logic [ps2mpd_pkg::BtnN-1:0]    btn_next;
	logic                           ev_last;
	ps2mpd_pkg::event_kind_t        ev_kind;
	logic [1:0]                     ev_btn;

	// lowest pending button first
	always_comb begin
		btn_sel = '0;
		ev_btn  = 2'd0;
		for (int i = ps2mpd_pkg::BtnN - 1; i >= 0; i--) begin
			if (btn_pend_q[i]) begin
				btn_sel = ps2mpd_pkg::BtnN'(1) << i;
				ev_btn  = 2'(i + 1);
			end
		end
	end

	always_comb begin
		if (move_pend_q) begin
			ev_kind  = ps2mpd_pkg::EV_MOVE;
			btn_next = btn_pend_q;
			ev_last  = (btn_pend_q == '0);
		end else begin
			ev_kind  = ((prev_q & btn_sel) != '0) ? ps2mpd_pkg::EV_RELEASED
			                                      : ps2mpd_pkg::EV_PRESSED;
			btn_next = btn_pend_q & ~btn_sel;
			ev_last  = (btn_next == '0);
		end
	end

	assign slot_free = !out_valid || out_ready;
	assign adv       = cur_valid_q && slot_free;
	assign job_pop   = job_avail && (!cur_valid_q || (adv && ev_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			move_pend_q <= 1'b0;
			btn_pend_q  <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_valid_q <= 1'b1;
				move_pend_q <= job.has_move;
				btn_pend_q  <= job.changed;
			end else if (adv) begin
				cur_valid_q <= !ev_last;
				move_pend_q <= 1'b0;
				btn_pend_q  <= btn_next;
			end
			if (slot_free) begin
				out_valid <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			prev_q <= job.prev;
			dx_q   <= job.dx;
			dy_q   <= job.dy;
		end
		if (adv) begin
			event_kind    <= ev_kind;
			last          <= ev_last;
			move_x        <= move_pend_q ? dx_q : 8'd0;
			move_y        <= move_pend_q ? dy_q : 8'd0;
			button_number <= move_pend_q ? 2'd0 : ev_btn;
		end
	end

endmodule

/* sv/ps2_mouse_packet_decoder_top.sv */
// Top level of the PS/2 mouse packet decoder.
// Each job passes the job queue and the event generator's job registers before output.
// Throughput: one input byte per cycle while the queue has room; events leave one per
// cycle if m_tready is high, up to 4 per packet; a 2-entry job queue decouples them.
// Reset (arst_n, async, active low) clears the byte position, button state, queue
// and output valid; packet bytes are only written, never cleared.
module ps2_mouse_packet_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] aux_flag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] move_x, [15:8] move_y, [17:16] button_number
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast
);

	ps2mpd_pkg::job_t         push_job;
	ps2mpd_pkg::job_t         head_job;
	ps2mpd_pkg::queue_ctl_t   qctl;
	ps2mpd_pkg::event_kind_t  kind;
	logic                     push;
	logic                     pop;
	logic [7:0]               mx;
	logic [7:0]               my;
	logic [1:0]               btn;

	ps2mpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.aux_flag   (s_tuser[0]),
		.data_byte  (s_tdata),
		.queue_full (qctl.full),
		.job_push   (push),
		.job        (push_job)
	);

	ps2mpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.ctl    (qctl)
	);

	ps2mpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_avail     (!qctl.empty),
		.job           (head_job),
		.job_pop       (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.event_kind    (kind),
		.move_x        (mx),
		.move_y        (my),
		.button_number (btn),
		.last          (m_tlast)
	);

	assign m_tdata = {6'd0, btn, my, mx};
	assign m_tuser = kind;

	// the front end never offers a job the queue cannot take
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qctl.full) else $error("job pushed into full queue");

	// a pop always hands a job to the back end
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qctl.pop) else $error("pop from empty queue");

	// move events carry no button, button events carry no motion
	a_move_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind == ps2mpd_pkg::EV_MOVE) |-> (btn == 2'd0))
		else $error("move event with button number");

	a_button_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind != ps2mpd_pkg::EV_MOVE) |-> (mx == 8'd0 && my == 8'd0 && btn != 2'd0))
		else $error("malformed button event");

endmodule
